// ===== src/slsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Slew-limited throttle and servo mapper: shared package
// Operation codes, register map, reset values, divider constants and the
// types passed between the lanes, the merging stage and the top level.
// ----------------------------------------------------------------------------
package slsm_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// Register indexes (byte address is eight times the index).
	localparam logic [2:0] REG_SERVO_A   = 3'd0;
	localparam logic [2:0] REG_SERVO_B   = 3'd1;
	localparam logic [2:0] REG_SERVO_C   = 3'd2;
	localparam logic [2:0] REG_ESC       = 3'd3;
	localparam logic [2:0] REG_INTERVAL  = 3'd4;
	localparam logic [2:0] REG_SLEW_STEP = 3'd5;
	localparam logic [2:0] REG_MAX_ANGLE = 3'd6;

	// Register reset values.
	localparam logic [15:0] INTERVAL_RESET  = 16'd20;
	localparam logic [16:0] SLEW_STEP_RESET = 17'd437;
	localparam logic [16:0] MAX_ANGLE_RESET = 17'd17157;

	// Full throttle in Q.16.
	localparam logic [16:0] THROTTLE_FULL = 17'h10000;

	// Number of servo lanes and depth of the lane pipeline.
	localparam int unsigned NUM_LANES  = 3;
	localparam int unsigned LANE_DEPTH = 7;

	// Division by pi/2 in Q.16 (102944 = 32 * 3217): a shift by five, then a
	// reciprocal multiply by floor(2^29 / 3217) with one correction step.
	localparam logic [34:0] HALF_PI_Q16   = 35'd102944;
	localparam logic [11:0] DIV_ODD       = 12'd3217;
	localparam logic [17:0] DIV_RECIP     = 18'd166885;

	// Calibration of one servo channel.
	typedef struct packed {
		logic [15:0] neg_end;
		logic [15:0] centre;
		logic [15:0] pos_end;
	} servo_cal_t;

	// Pipeline control shared by all lanes.
	typedef struct packed {
		logic adv;
		logic zero;
	} lane_ctrl_t;

	// Unsaturated compare out of a lane.
	typedef logic signed [19:0] lane_sum_t;

endpackage

// ===== src/slsm_lane.sv =====
// ----------------------------------------------------------------------------
// Slew-limited throttle and servo mapper: servo lane
// Clamps one angle, picks the slope for its sign, multiplies and divides the
// product by pi/2 with floor rounding, and adds the centre compare.
// ----------------------------------------------------------------------------
module slsm_lane
	import slsm_pkg::*;
(
	input  logic              clk,
	input  lane_ctrl_t        ctrl,
	input  servo_cal_t        cal,
	input  logic signed [17:0] angle,
	input  logic [16:0]       max_angle,
	output lane_sum_t         sum
);

	logic signed [17:0] a_s1;
	logic signed [16:0] slope_s1;
	logic [15:0]        centre_s1;
	logic signed [34:0] prod_s2;
	logic [15:0]        centre_s2;
	logic [28:0]        v_s3;
	logic               neg_s3;
	logic [15:0]        centre_s3;
	logic [46:0]        p_s4;
	logic [28:0]        v_s4;
	logic               neg_s4;
	logic [15:0]        centre_s4;
	logic [17:0]        q0_s5;
	logic [28:0]        v_s5;
	logic               neg_s5;
	logic [15:0]        centre_s5;
	logic [17:0]        q_s6;
	logic               neg_s6;
	logic [15:0]        centre_s6;
	lane_sum_t          sum_s7;

	logic signed [18:0] a_ext;
	logic signed [18:0] lim;
	logic signed [18:0] a_cl;
	logic signed [16:0] slope_c;
	logic [34:0]        mag;
	logic [34:0]        u_c;
	logic [29:0]        qd_c;
	logic [28:0]        r_c;
	logic signed [19:0] q_signed;

	// Stage 1: clamp the angle and choose the slope by its sign.
	always_comb begin
		a_ext = 19'(angle);
		lim   = $signed({2'b00, max_angle});
		if (a_ext > lim) begin
			a_cl = lim;
		end else if (a_ext < -lim) begin
			a_cl = -lim;
		end else begin
			a_cl = a_ext;
		end
		if (ctrl.zero) begin
			a_cl = '0;
		end
		if (a_cl > 19'sd0) begin
			slope_c = $signed({1'b0, cal.pos_end}) - $signed({1'b0, cal.centre});
		end else begin
			slope_c = $signed({1'b0, cal.centre}) - $signed({1'b0, cal.neg_end});
		end
	end

	// Stage 3: work on the magnitude, biased for floor rounding when negative.
	always_comb begin
		mag = prod_s2[34] ? 35'(-prod_s2) : 35'(prod_s2);
		u_c = prod_s2[34] ? mag + (HALF_PI_Q16 - 35'd1) : mag;
	end

	// Stage 6: one correction step on the reciprocal estimate.
	always_comb begin
		qd_c = {12'd0, q0_s5} * {18'd0, DIV_ODD};
		r_c  = v_s5 - qd_c[28:0];
	end

	// Stage 7: apply the sign and add the centre.
	always_comb begin
		q_signed = neg_s6 ? -$signed({2'b00, q_s6}) : $signed({2'b00, q_s6});
	end

	// Lane pipeline, frozen while the result cannot be handed on.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			a_s1      <= a_cl[17:0];
			slope_s1  <= slope_c;
			centre_s1 <= cal.centre;

			prod_s2   <= slope_s1 * a_s1;
			centre_s2 <= centre_s1;

			v_s3      <= u_c[33:5];
			neg_s3    <= prod_s2[34];
			centre_s3 <= centre_s2;

			p_s4      <= v_s3 * DIV_RECIP;
			v_s4      <= v_s3;
			neg_s4    <= neg_s3;
			centre_s4 <= centre_s3;

			q0_s5     <= p_s4[46:29];
			v_s5      <= v_s4;
			neg_s5    <= neg_s4;
			centre_s5 <= centre_s4;

			q_s6      <= (r_c >= 29'(DIV_ODD)) ? q0_s5 + 18'd1 : q0_s5;
			neg_s6    <= neg_s5;
			centre_s6 <= centre_s5;

			sum_s7    <= $signed({4'b0000, centre_s6}) + q_signed;
		end
	end

	assign sum = sum_s7;

endmodule

// ===== src/slsm_merge.sv =====
// ----------------------------------------------------------------------------
// Slew-limited throttle and servo mapper: merging stage
// Finishes the ESC compare, saturates all four compares and holds the
// result in the output register until the master side takes it.
// ----------------------------------------------------------------------------
module slsm_merge
	import slsm_pkg::*;
#(
	parameter int unsigned COMPARE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [15:0]        esc_lo,
	input  logic signed [34:0] esc_prod,
	input  lane_sum_t          lane_sum [NUM_LANES],
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [63:0]        m_tdata
);

	localparam logic [32:0] SAT_TOP = (33'd1 << COMPARE_BITS) - 33'd1;

	logic               out_valid_q;
	logic [63:0]        out_data_q;
	logic signed [19:0] esc_sum;
	logic [63:0]        merged;

	// Saturate to the compare range, then keep the low sixteen bits.
	function automatic logic [15:0] saturate(input lane_sum_t v);
		logic [32:0] wide;
		wide = {13'd0, v};
		if (v < 20'sd0) begin
			return 16'd0;
		end else if (wide > SAT_TOP) begin
			return SAT_TOP[15:0];
		end
		return v[15:0];
	endfunction

	// ESC compare: zero-throttle compare plus the floored scaled span.
	always_comb begin
		esc_sum = $signed({4'b0000, esc_lo}) + 20'(esc_prod >>> 16);
		merged  = {saturate(lane_sum[2]), saturate(lane_sum[1]),
			saturate(lane_sum[0]), saturate(esc_sum)};
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= merged;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== src/slew_limited_throttle_servo_pwm_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Slew-limited throttle and servo mapper: top level
// Holds the registers and the throttle state, runs three servo lanes side by
// side and merges their compares with the ESC compare into one result.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tdata: angles, throttle, time; tuser: op
// m_*       out        m_tvalid/m_tready  tdata: ESC and three servo compares
// APB       in/out     psel/penable       seven registers at 8-byte spacing
//
// A set or stop item passes through seven stages in each servo lane (multiply,
// reciprocal divide, correction) and then the output register. A tick item
// is done in the cycle of its transfer. The next item is taken as soon as a
// result sits in the output register. A stalled result freezes the lane
// pipeline. Reset is asynchronous, clears the control and throttle state and
// sets the registers to their reset values.
// ----------------------------------------------------------------------------
module slew_limited_throttle_servo_pwm_mapper_top
	import slsm_pkg::*;
#(
	parameter int unsigned COMPARE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: throttle[17:0], angle_a[35:18], angle_b[53:36], angle_c[71:54],
	// now_time[103:72]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: esc_compare[15:0], servo_compare_a[31:16], servo_compare_b[47:32],
	// servo_compare_c[63:48]
	output logic [63:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [47:0] servo_cal_q [NUM_LANES];
	logic [31:0] esc_cal_q;
	logic [15:0] interval_q;
	logic [16:0] slew_step_q;
	logic [16:0] max_angle_q;

	logic [16:0] tgt_q;
	logic [16:0] cur_q;
	logic [31:0] last_q;

	logic                  busy_q;
	logic [LANE_DEPTH-1:0] vld_q;

	logic [15:0]        esc_lo_q;
	logic signed [16:0] esc_span_q;
	logic [16:0]        esc_thr_q;
	logic signed [34:0] esc_prod_q;

	logic               accept;
	logic               emit;
	logic               adv;
	logic               load;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;
	lane_ctrl_t         lane_ctrl;
	lane_sum_t          lane_sum [NUM_LANES];
	logic signed [17:0] lane_angle [NUM_LANES];

	logic [1:0]         op;
	logic signed [17:0] thr_in;
	logic [31:0]        now_in;
	logic [16:0]        thr_cl;
	logic [31:0]        elapsed;
	logic signed [18:0] diff;
	logic signed [18:0] step_s;
	logic [17:0]        cur_up;
	logic [17:0]        cur_dn;
	logic [16:0]        cur_next;

	// Input fields.
	assign op            = s_tuser;
	assign thr_in        = $signed(s_tdata[17:0]);
	assign lane_angle[0] = $signed(s_tdata[35:18]);
	assign lane_angle[1] = $signed(s_tdata[53:36]);
	assign lane_angle[2] = $signed(s_tdata[71:54]);
	assign now_in        = s_tdata[103:72];

	// Handshake and pipeline control.
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign emit     = accept && (op inside {OP_SET, OP_STOP});
	assign adv      = !(vld_q[LANE_DEPTH-1] && m_tvalid && !m_tready);
	assign load     = vld_q[LANE_DEPTH-1] && adv;

	assign lane_ctrl.adv  = adv;
	assign lane_ctrl.zero = (op == OP_STOP);

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_SERVO_A:   prdata = {16'd0, servo_cal_q[0]};
			REG_SERVO_B:   prdata = {16'd0, servo_cal_q[1]};
			REG_SERVO_C:   prdata = {16'd0, servo_cal_q[2]};
			REG_ESC:       prdata = {32'd0, esc_cal_q};
			REG_INTERVAL:  prdata = {48'd0, interval_q};
			REG_SLEW_STEP: prdata = {47'd0, slew_step_q};
			REG_MAX_ANGLE: prdata = {47'd0, max_angle_q};
			default:       prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_cal_q[0] <= '0;
			servo_cal_q[1] <= '0;
			servo_cal_q[2] <= '0;
			esc_cal_q      <= '0;
			interval_q     <= INTERVAL_RESET;
			slew_step_q    <= SLEW_STEP_RESET;
			max_angle_q    <= MAX_ANGLE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SERVO_A:   servo_cal_q[0] <= pwdata[47:0];
				REG_SERVO_B:   servo_cal_q[1] <= pwdata[47:0];
				REG_SERVO_C:   servo_cal_q[2] <= pwdata[47:0];
				REG_ESC:       esc_cal_q      <= pwdata[31:0];
				REG_INTERVAL:  interval_q     <= pwdata[15:0];
				REG_SLEW_STEP: slew_step_q    <= pwdata[16:0];
				REG_MAX_ANGLE: max_angle_q    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// Throttle clamp for set items and one slew step for tick items.
	always_comb begin
		if (thr_in > $signed({1'b0, THROTTLE_FULL})) begin
			thr_cl = THROTTLE_FULL;
		end else if (thr_in < 18'sd0) begin
			thr_cl = 17'd0;
		end else begin
			thr_cl = thr_in[16:0];
		end
		elapsed = now_in - last_q;
		diff    = $signed({2'b00, tgt_q}) - $signed({2'b00, cur_q});
		step_s  = $signed({2'b00, slew_step_q});
		cur_up  = {1'b0, cur_q} + {1'b0, slew_step_q};
		cur_dn  = {1'b0, cur_q} - {1'b0, slew_step_q};
		if (diff > step_s) begin
			cur_next = cur_up[16:0];
		end else if (diff < -step_s) begin
			cur_next = cur_dn[16:0];
		end else begin
			cur_next = tgt_q;
		end
	end

	// Throttle state, busy flag and lane valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q  <= '0;
			cur_q  <= '0;
			last_q <= '0;
			busy_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (accept) begin
				case (op)
					OP_SET: begin
						tgt_q <= thr_cl;
					end
					OP_TICK: begin
						if (elapsed >= {16'd0, interval_q}) begin
							last_q <= now_in;
							cur_q  <= cur_next;
						end
					end
					OP_STOP: begin
						tgt_q <= '0;
						cur_q <= '0;
					end
					default: ;
				endcase
			end
			if (emit) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				vld_q <= {vld_q[LANE_DEPTH-2:0], emit};
			end
		end
	end

	// ESC operands are captured with the transfer and held while it is at work.
	always_ff @(posedge clk) begin
		if (emit) begin
			esc_lo_q   <= esc_cal_q[15:0];
			esc_span_q <= $signed({1'b0, esc_cal_q[31:16]}) - $signed({1'b0, esc_cal_q[15:0]});
			esc_thr_q  <= (op == OP_STOP) ? 17'd0 : cur_q;
		end
		esc_prod_q <= esc_span_q * $signed({1'b0, esc_thr_q});
	end

	// Servo lanes.
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		slsm_lane u_lane (
			.clk       (clk),
			.ctrl      (lane_ctrl),
			.cal       (servo_cal_t'(servo_cal_q[k])),
			.angle     (lane_angle[k]),
			.max_angle (max_angle_q),
			.sum       (lane_sum[k])
		);
	end

	// Merge and output register.
	slsm_merge #(
		.COMPARE_BITS (COMPARE_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.esc_lo   (esc_lo_q),
		.esc_prod (esc_prod_q),
		.lane_sum (lane_sum),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// The current throttle never leaves the range 0 to full throttle.
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= THROTTLE_FULL)
		else $error("current throttle above full throttle");

	// At most one item is in the lanes, and only while the block is busy.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q != '0) |-> (busy_q && $onehot0(vld_q)))
		else $error("lane pipeline holds more than the item in flight");

	// A tick never starts a result.
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_TICK) |=> !vld_q[0])
		else $error("tick item entered the lanes");

	// A stop clears both throttles.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_STOP) |=> (cur_q == '0 && tgt_q == '0))
		else $error("stop left throttle state set");

endmodule

// ===== test/tb_slew_limited_throttle_servo_pwm_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the slew-limited throttle and servo compare mapper
// Writes and reads back the seven registers over APB. Sends set, tick, stop
// and unused-code items on the input stream. A shadow model of the throttle
// state and the registers predicts every ESC and servo compare, and each
// result on the output stream is checked field by field. Random idling on
// both streams and several register settings, extremes among them, shake
// out timing and arithmetic corner cases.
// ----------------------------------------------------------------------------
module tb_slew_limited_throttle_servo_pwm_mapper_top;
	import slsm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          COMPARE_BITS   = 16;
	localparam int          RESULT_LATENCY = 8;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          SEGMENT_ITEMS  = 190;
	localparam longint      FULL_Q16       = 65536;
	localparam longint      QUARTER_TURN   = 102944;
	localparam logic [1:0]  OP_UNUSED      = 2'd3;

	// One result: ESC compare in the low bits, then servo A, B and C.
	typedef struct packed {
		logic [15:0] servo_c;
		logic [15:0] servo_b;
		logic [15:0] servo_a;
		logic [15:0] esc;
	} compare_set_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [1:0]   s_tuser = OP_SET;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [5:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;

	// Shadow copy of the registers.
	servo_cal_t   cfg_servo [3] = '{48'd0, 48'd0, 48'd0};
	logic [31:0]  cfg_esc = 32'd0;
	logic [15:0]  cfg_interval = INTERVAL_RESET;
	logic [16:0]  cfg_step = SLEW_STEP_RESET;
	logic [16:0]  cfg_max_angle = MAX_ANGLE_RESET;

	// Shadow copy of the throttle state.
	logic [16:0]  target_throttle_q16 = '0;
	logic [16:0]  current_throttle_q16 = '0;
	logic [31:0]  last_step_ms = '0;

	compare_set_t compare_expect_q [$];

	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  n_set = 0;
	int unsigned  n_tick = 0;
	int unsigned  n_stop = 0;
	int unsigned  n_unused = 0;
	int unsigned  n_checked = 0;
	int unsigned  stall_cycles = 0;

	slew_limited_throttle_servo_pwm_mapper_top #(
		.COMPARE_BITS(COMPARE_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 50 MHz clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
			want);
		mismatch_count++;
	endtask

	// Floor division for a positive divisor.
	function automatic longint floor_quot(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0) begin
			q -= 1;
		end
		return q;
	endfunction

	function automatic logic [15:0] saturate_compare(longint v);
		longint top;
		top = (longint'(1) << COMPARE_BITS) - 1;
		if (v < 0) begin
			v = 0;
		end
		if (v > top) begin
			v = top;
		end
		return v[15:0];
	endfunction

	// Piecewise-linear servo compare: separate slopes either side of centre.
	function automatic logic [15:0] servo_compare_of(servo_cal_t cal, logic [17:0] raw);
		longint ang, lim, pos_end, centre, neg_end, slope;
		ang = longint'($signed(raw));
		lim = longint'(cfg_max_angle);
		pos_end = longint'(cal.pos_end);
		centre = longint'(cal.centre);
		neg_end = longint'(cal.neg_end);
		if (ang > lim) begin
			ang = lim;
		end
		if (ang < -lim) begin
			ang = -lim;
		end
		slope = (ang > 0) ? (pos_end - centre) : (centre - neg_end);
		return saturate_compare(centre + floor_quot(slope * ang, QUARTER_TURN));
	endfunction

	// Updates the throttle state for one accepted item and queues its result.
	function automatic void apply_item(logic [1:0] op, logic [103:0] d);
		compare_set_t res;
		longint thr, lo, hi, tgt, cur, diff, step;
		logic [31:0] now_ms, elapsed;
		case (op)
			OP_SET: begin
				n_set++;
				thr = longint'($signed(d[17:0]));
				if (thr > FULL_Q16) begin
					thr = FULL_Q16;
				end
				if (thr < 0) begin
					thr = 0;
				end
				target_throttle_q16 = thr[16:0];
				lo = longint'(cfg_esc[15:0]);
				hi = longint'(cfg_esc[31:16]);
				cur = longint'(current_throttle_q16);
				res.esc = saturate_compare(lo + floor_quot((hi - lo) * cur, FULL_Q16));
				res.servo_a = servo_compare_of(cfg_servo[0], d[35:18]);
				res.servo_b = servo_compare_of(cfg_servo[1], d[53:36]);
				res.servo_c = servo_compare_of(cfg_servo[2], d[71:54]);
				compare_expect_q.push_back(res);
			end
			OP_TICK: begin
				n_tick++;
				now_ms = d[103:72];
				elapsed = now_ms - last_step_ms;
				if (elapsed >= {16'd0, cfg_interval}) begin
					last_step_ms = now_ms;
					tgt = longint'(target_throttle_q16);
					cur = longint'(current_throttle_q16);
					step = longint'(cfg_step);
					diff = tgt - cur;
					if (diff > step) begin
						cur = cur + step;
					end else if (diff < -step) begin
						cur = cur - step;
					end else begin
						cur = tgt;
					end
					current_throttle_q16 = cur[16:0];
				end
			end
			OP_STOP: begin
				n_stop++;
				target_throttle_q16 = '0;
				current_throttle_q16 = '0;
				res.esc = saturate_compare(longint'(cfg_esc[15:0]));
				res.servo_a = saturate_compare(longint'(cfg_servo[0].centre));
				res.servo_b = saturate_compare(longint'(cfg_servo[1].centre));
				res.servo_c = saturate_compare(longint'(cfg_servo[2].centre));
				compare_expect_q.push_back(res);
			end
			default: begin
				n_unused++;
			end
		endcase
	endfunction

	// Checks each result against the oldest expectation, then predicts the
	// outcome of an input transfer in the same cycle.
	always @(posedge clk) begin : result_check
		compare_set_t got_c;
		compare_set_t exp_c;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (compare_expect_q.size() == 0) begin
					report_mismatch("result transfer with none expected", m_tdata, 64'd0);
				end else begin
					got_c = m_tdata;
					exp_c = compare_expect_q.pop_front();
					n_checked++;
					if (got_c.esc != exp_c.esc) begin
						report_mismatch("esc_compare", 64'(got_c.esc), 64'(exp_c.esc));
					end
					if (got_c.servo_a != exp_c.servo_a) begin
						report_mismatch("servo_compare_a", 64'(got_c.servo_a),
							64'(exp_c.servo_a));
					end
					if (got_c.servo_b != exp_c.servo_b) begin
						report_mismatch("servo_compare_b", 64'(got_c.servo_b),
							64'(exp_c.servo_b));
					end
					if (got_c.servo_c != exp_c.servo_c) begin
						report_mismatch("servo_compare_c", 64'(got_c.servo_c),
							64'(exp_c.servo_c));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_item(s_tuser, s_tdata);
			end
		end
	end

	// Ends the run when no transfer has happened for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_slew_limited_throttle_servo_pwm_mapper_top: FAIL");
			$finish;
		end
	end

	// One APB access: setup cycle, then access cycle until pready.
	task automatic apb_transfer(input logic write, input logic [2:0] idx,
			input logic [63:0] wdata, output logic [63:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 3'b000};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [63:0] shadow_value(logic [2:0] idx);
		case (idx)
			REG_SERVO_A:   return 64'(cfg_servo[0]);
			REG_SERVO_B:   return 64'(cfg_servo[1]);
			REG_SERVO_C:   return 64'(cfg_servo[2]);
			REG_ESC:       return 64'(cfg_esc);
			REG_INTERVAL:  return 64'(cfg_interval);
			REG_SLEW_STEP: return 64'(cfg_step);
			REG_MAX_ANGLE: return 64'(cfg_max_angle);
			default:       return 64'd0;
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		logic [63:0] unused_rd;
		case (idx)
			REG_SERVO_A:   cfg_servo[0] = value[47:0];
			REG_SERVO_B:   cfg_servo[1] = value[47:0];
			REG_SERVO_C:   cfg_servo[2] = value[47:0];
			REG_ESC:       cfg_esc = value[31:0];
			REG_INTERVAL:  cfg_interval = value[15:0];
			REG_SLEW_STEP: cfg_step = value[16:0];
			REG_MAX_ANGLE: cfg_max_angle = value[16:0];
			default: ;
		endcase
		apb_transfer(1'b1, idx, value, unused_rd);
	endtask

	task automatic read_check(input logic [2:0] idx);
		logic [63:0] rd;
		apb_transfer(1'b0, idx, 64'd0, rd);
		if (rd != shadow_value(idx)) begin
			report_mismatch($sformatf("register %0d read-back", idx), rd, shadow_value(idx));
		end
	endtask

	task automatic configure_all(input logic [63:0] cal_a, cal_b, cal_c, esc,
			input logic [63:0] interval, step, max_angle);
		write_reg(REG_SERVO_A, cal_a);
		write_reg(REG_SERVO_B, cal_b);
		write_reg(REG_SERVO_C, cal_c);
		write_reg(REG_ESC, esc);
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_SLEW_STEP, step);
		write_reg(REG_MAX_ANGLE, max_angle);
	endtask

	// Ends the current item and lets every result, and a tick still in
	// flight, work its way out before the registers are touched.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (compare_expect_q.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 4) @(posedge clk);
	endtask

	// Sends one item, with a random idle gap before it, and waits for its
	// transfer.
	task automatic send_item(input logic [1:0] op, input logic [17:0] thr,
			input logic [17:0] ang_a, ang_b, ang_c, input logic [31:0] now_ms);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now_ms, ang_c, ang_b, ang_a, thr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [63:0] pack_cal(logic [15:0] neg_end, centre, pos_end);
		return {16'($urandom_range(0, 65535)), neg_end, centre, pos_end};
	endfunction

	function automatic logic [63:0] random_word64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [17:0] random_angle();
		int lim;
		lim = int'(cfg_max_angle);
		if ($urandom_range(0, 3) == 0) begin
			return 18'($urandom);
		end
		return 18'(int'($urandom_range(0, 2 * lim + 200)) - (lim + 100));
	endfunction

	function automatic logic [17:0] random_throttle();
		if ($urandom_range(0, 4) == 0) begin
			return 18'($urandom);
		end
		return 18'($urandom_range(0, 67536));
	endfunction

	// Registers must come out of reset at their documented values.
	task automatic test_register_reset_values();
		for (int i = 0; i <= REG_MAX_ANGLE; i++) begin
			read_check(3'(i));
		end
	endtask

	// Random values, upper bits included, must read back masked to width.
	task automatic test_register_access();
		for (int i = 0; i <= REG_MAX_ANGLE; i++) begin
			write_reg(3'(i), random_word64());
		end
		for (int i = 0; i <= REG_MAX_ANGLE; i++) begin
			read_check(3'(i));
		end
	endtask

	// Field extremes, clamping, extrapolation, swapped slopes, the slew
	// timing with and without wrap, stop, and the unused operation code.
	task automatic test_directed_cases();
		configure_all(pack_cal(16'd1000, 16'd30000, 16'd60000),
			pack_cal(16'd60000, 16'd30000, 16'd1000),
			pack_cal(16'd65535, 16'd0, 16'd65535),
			{$urandom, 16'd6000, 16'd3000}, 64'd20, 64'd20000, 64'd131071);
		send_item(OP_SET, 18'h1FFFF, 18'h1FFFF, 18'h20000, 18'd0, 32'd0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd5);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd25);
		send_item(OP_SET, 18'h20000, 18'd102944, 18'(-102944), 18'd1, 32'd0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd45);
		send_item(OP_SET, 18'd65536, 18'h3FFFF, 18'd17157, 18'(-17157), 32'd0);
		// Near the top of the time range, then across the wrap.
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'hFFFF_FFF0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd4);
		send_item(OP_SET, 18'd0, 18'd50000, 18'd131071, 18'(-131071), 32'hFFFF_FFFF);
		send_item(OP_UNUSED, 18'h2AAAA, 18'h15555, 18'h3FFFF, 18'h20000, 32'hA5A5_5A5A);
		send_item(OP_STOP, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
		// Stop keeps the time of the last step, so this tick is too early.
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd22);
		send_item(OP_SET, 18'd65535, 18'd0, 18'd0, 18'd0, 32'd0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd24);
		send_item(OP_SET, 18'd30000, 18'h20000, 18'h1FFFF, 18'd0, 32'd0);
		wait_idle();
		// Zero interval and zero step.
		write_reg(REG_INTERVAL, 64'd0);
		write_reg(REG_SLEW_STEP, 64'd0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd24);
		send_item(OP_SET, 18'd20000, 18'd0, 18'd0, 18'd0, 32'd0);
		send_item(OP_TICK, 18'd0, 18'd0, 18'd0, 18'd0, 32'd24);
		send_item(OP_SET, 18'd0, 18'd1, 18'h3FFFF, 18'd0, 32'd0);
		wait_idle();
	endtask

	// Random traffic in segments, each with its own register setting and
	// idling pattern. Ticks mostly follow a running time that advances by
	// about the interval, with occasional jumps.
	task automatic test_random_traffic();
		int sent;
		int pick;
		logic [31:0] sim_ms;
		for (int seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 20;
				recv_idle_pct = 47;
			end else if (seg < 4) begin
				send_idle_pct = 47;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg)
				0: configure_all(random_word64(), random_word64(), random_word64(),
					random_word64(), 64'd20, 64'd437, 64'd17157);
				1: configure_all(random_word64(), random_word64(), random_word64(),
					64'hFFFF_0000, 64'd1, 64'd65536, 64'd131071);
				2: configure_all(random_word64(), random_word64(), random_word64(),
					64'h0000_FFFF, 64'd65535, 64'd1, 64'd0);
				3: configure_all(random_word64(), random_word64(), random_word64(),
					random_word64(), 64'd0, 64'd0, 64'($urandom_range(0, 131071)));
				default: configure_all(pack_cal(16'($urandom_range(0, 30000)),
					16'($urandom_range(20000, 40000)), 16'($urandom_range(30000, 65535))),
					random_word64(), random_word64(), random_word64(),
					64'($urandom_range(1, 500)), 64'($urandom_range(1, 65536)),
					64'($urandom_range(0, 131071)));
			endcase
			sim_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
				: $urandom;
			sent = 0;
			while (sent < SEGMENT_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send_item(OP_SET, random_throttle(), random_angle(), random_angle(),
						random_angle(), $urandom);
					sent++;
				end else if (pick < 85) begin
					if ($urandom_range(0, 19) == 0) begin
						sim_ms = $urandom;
					end else begin
						sim_ms = sim_ms + $urandom_range(0, 2 * cfg_interval + 2);
					end
					send_item(OP_TICK, 18'($urandom), 18'($urandom), 18'($urandom),
						18'($urandom), sim_ms);
					sent++;
				end else if (pick < 93) begin
					send_item(OP_STOP, 18'($urandom), 18'($urandom), 18'($urandom),
						18'($urandom), $urandom);
					sent++;
				end else begin
					send_item(OP_UNUSED, 18'($urandom), 18'($urandom), 18'($urandom),
						18'($urandom), $urandom);
					sent++;
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		send_idle_pct = 20;
		recv_idle_pct = 47;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_register_reset_values();
		test_register_access();
		test_directed_cases();
		test_random_traffic();
		wait_idle();
		$display("Run covered %0d set, %0d tick, %0d stop and %0d unused-code items.",
			n_set, n_tick, n_stop, n_unused);
		$display("%0d results compared over six register settings, %0d mismatches.",
			n_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_slew_limited_throttle_servo_pwm_mapper_top: PASS");
		end else begin
			$display("tb_slew_limited_throttle_servo_pwm_mapper_top: FAIL");
		end
		$finish;
	end

endmodule
